[design/hcbd_pkg.sv]
// Shared types, character codes and size-line helper functions of the chunked body decoder.
package hcbd_pkg;

  localparam int SIZE_BITS = 64;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_VT    = 8'h0B;
  localparam logic [7:0] CHAR_FF    = 8'h0C;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_LO_X  = 8'h78;
  localparam logic [7:0] CHAR_UP_X  = 8'h58;

  typedef enum logic [2:0] {
    PH_SIZE = 3'd0,
    PH_DATA = 3'd1,
    PH_CR   = 3'd2,
    PH_LF   = 3'd3,
    PH_DONE = 3'd4,
    PH_ERR  = 3'd5,
    PH_OVF  = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERR   = 2'd2,
    KIND_TRUNC = 2'd3
  } kind_t;

  typedef struct packed {
    phase_t               phase;
    logic [SIZE_BITS-1:0] rem_count;
    logic                 digit_seen;
    logic                 digits_ended;
    logic                 prefix_zero_pending;
    logic                 cr_pending;
  } state_t;

  typedef struct packed {
    logic       vld;
    kind_t      kind;
    logic [7:0] payload_byte;
    logic       chunk_last;
  } result_t;

  // Bit 4 is set when the character is a hex digit; bits 3:0 hold its value.
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [4:0] h;
    h = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h = {1'b1, 4'(c - 8'h37)};
    end
    return h;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) ||
           (c == CHAR_VT) || (c == CHAR_FF) || (c == CHAR_CR);
  endfunction

  // One ordinary character of the size line, outside the closing CR LF.
  function automatic state_t line_char(state_t s, logic [7:0] c);
    state_t     r;
    logic [4:0] h;
    r = s;
    h = hex_digit(c);
    if (s.phase == PH_SIZE && !s.digits_ended) begin
      if (!s.digit_seen) begin
        if (!is_blank(c)) begin
          if (!h[4]) begin
            r.digits_ended = 1'b1;
          end else begin
            r.digit_seen          = 1'b1;
            r.prefix_zero_pending = (h[3:0] == 4'd0);
            r.rem_count           = SIZE_BITS'(h[3:0]);
          end
        end
      end else if (s.prefix_zero_pending && (c == CHAR_LO_X || c == CHAR_UP_X)) begin
        r.prefix_zero_pending = 1'b0;
      end else begin
        r.prefix_zero_pending = 1'b0;
        if (!h[4]) begin
          r.digits_ended = 1'b1;
        end else if (s.rem_count[SIZE_BITS-1 -: 4] != 4'd0) begin
          r.phase = PH_OVF;
        end else begin
          r.rem_count = {s.rem_count[SIZE_BITS-5:0], h[3:0]};
        end
      end
    end
    return r;
  endfunction

endpackage

[design/http_chunked_body_decoder.sv]
// Top level of the HTTP/1.1 chunked transfer body decoder.
//
// The input channel carries one item per raw body byte (in_body_byte), or a
// stream-closed mark (in_stream_closed high, byte ignored). The result channel
// carries at most one item per input item: a payload byte with its chunk_last
// flag, an end-of-body mark, a format error, or a truncation report.
// Size-line bytes (but for the LF that ends a zero-size or faulty size line),
// the CR LF after each chunk and all bytes after the end of the body or an
// error give no result item. An accepted item is held in the input register;
// the decode logic then updates the state and loads the output register, whose
// result shows on the out_ ports until the receiver takes it.
// One item is taken every cycle while the receiver does not stall: the state
// update is a single pass through the decode logic, whose longest path is the
// 64-bit chunk count (shift-in of a hex digit or a decrement with a compare).
// When the receiver stalls, the result waits in the output register while an
// empty input register still takes one more item; then in_ready drops.
// Reset (rst_n low, synchronous) empties both registers and returns the
// decoder to the start of a size line. End of body and errors are sticky
// until the next reset.
module http_chunked_body_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_body_byte,
  input  logic       in_stream_closed,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_payload_byte,
  output logic       out_chunk_last
);

  // Input register.
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_closed_r;

  // Decoder state and its next value.
  hcbd_pkg::state_t  state_r;
  hcbd_pkg::state_t  state_nxt;
  hcbd_pkg::result_t step_res;

  // Output register.
  logic              out_valid_r;
  hcbd_pkg::result_t out_res_r;

  logic step_go;

  // The held item is decoded once the output register is free or being emptied.
  assign step_go  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step_go;

  hcbd_step u_step (
    .st            (state_r),
    .body_byte     (in_byte_r),
    .stream_closed (in_closed_r),
    .st_nxt        (state_nxt),
    .res           (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r   <= in_body_byte;
      in_closed_r <= in_stream_closed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: hcbd_pkg::PH_SIZE, rem_count: '0, digit_seen: 1'b0,
                   digits_ended: 1'b0, prefix_zero_pending: 1'b0, cr_pending: 1'b0};
    end else if (step_go) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_go) begin
      out_valid_r <= step_res.vld;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = 2'(out_res_r.kind);
  assign out_payload_byte = out_res_r.payload_byte;
  assign out_chunk_last   = out_res_r.chunk_last;

endmodule

[design/hcbd_step.sv]
// Combinational decode of one body byte against the current decoder state.
module hcbd_step (
  input  hcbd_pkg::state_t  st,
  input  logic [7:0]        body_byte,
  input  logic              stream_closed,
  output hcbd_pkg::state_t  st_nxt,
  output hcbd_pkg::result_t res
);

  always_comb begin
    hcbd_pkg::state_t ln;
    logic             active;
    ln     = st;
    st_nxt = st;
    res    = '{vld: 1'b0, kind: hcbd_pkg::KIND_DATA, payload_byte: 8'd0, chunk_last: 1'b0};
    active = (st.phase == hcbd_pkg::PH_SIZE) || (st.phase == hcbd_pkg::PH_OVF) ||
             (st.phase == hcbd_pkg::PH_DATA) || (st.phase == hcbd_pkg::PH_CR) ||
             (st.phase == hcbd_pkg::PH_LF);
    if (active) begin
      if (stream_closed) begin
        st_nxt.phase = hcbd_pkg::PH_ERR;
        res.vld      = 1'b1;
        res.kind     = (st.phase == hcbd_pkg::PH_DATA) ? hcbd_pkg::KIND_TRUNC
                                                       : hcbd_pkg::KIND_ERR;
      end else begin
        case (st.phase)
          hcbd_pkg::PH_DATA: begin
            st_nxt.rem_count = st.rem_count - (hcbd_pkg::SIZE_BITS)'(1);
            res.vld          = 1'b1;
            res.payload_byte = body_byte;
            if (st.rem_count == (hcbd_pkg::SIZE_BITS)'(1)) begin
              st_nxt.phase   = hcbd_pkg::PH_CR;
              res.chunk_last = 1'b1;
            end
          end
          hcbd_pkg::PH_CR: begin
            if (body_byte != hcbd_pkg::CHAR_CR) begin
              st_nxt.phase = hcbd_pkg::PH_ERR;
              res.vld      = 1'b1;
              res.kind     = hcbd_pkg::KIND_ERR;
            end else begin
              st_nxt.phase = hcbd_pkg::PH_LF;
            end
          end
          hcbd_pkg::PH_LF: begin
            if (body_byte != hcbd_pkg::CHAR_LF) begin
              st_nxt.phase = hcbd_pkg::PH_ERR;
              res.vld      = 1'b1;
              res.kind     = hcbd_pkg::KIND_ERR;
            end else begin
              st_nxt = '{phase: hcbd_pkg::PH_SIZE, rem_count: '0, digit_seen: 1'b0,
                         digits_ended: 1'b0, prefix_zero_pending: 1'b0, cr_pending: 1'b0};
            end
          end
          default: begin
            // Size line, with or without an overflowed value.
            if (st.cr_pending && body_byte == hcbd_pkg::CHAR_LF) begin
              st_nxt.cr_pending = 1'b0;
              if (st.phase == hcbd_pkg::PH_OVF || !st.digit_seen) begin
                st_nxt.phase = hcbd_pkg::PH_ERR;
                res.vld      = 1'b1;
                res.kind     = hcbd_pkg::KIND_ERR;
              end else if (st.rem_count == '0) begin
                st_nxt.phase = hcbd_pkg::PH_DONE;
                res.vld      = 1'b1;
                res.kind     = hcbd_pkg::KIND_END;
              end else begin
                st_nxt.phase               = hcbd_pkg::PH_DATA;
                st_nxt.digit_seen          = 1'b0;
                st_nxt.digits_ended        = 1'b0;
                st_nxt.prefix_zero_pending = 1'b0;
              end
            end else begin
              // A CR not followed by LF is an ordinary blank of the line.
              if (st.cr_pending) begin
                ln.cr_pending = 1'b0;
                ln = hcbd_pkg::line_char(ln, hcbd_pkg::CHAR_CR);
              end
              if (body_byte == hcbd_pkg::CHAR_CR) begin
                ln.cr_pending = 1'b1;
              end else begin
                ln = hcbd_pkg::line_char(ln, body_byte);
              end
              st_nxt = ln;
            end
          end
        endcase
      end
    end
  end

endmodule

[design/hcbd_checker.sv]
// Port-level assertions for the chunked body decoder, bound to its top level.
module hcbd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_payload_byte,
  input logic       out_chunk_last
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_kind) && $stable(out_payload_byte) &&
                                $stable(out_chunk_last))
    else $error("result item changed while stalled");

  // Marks other than payload carry a cleared byte and no chunk end.
  a_mark_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != 2'(hcbd_pkg::KIND_DATA) |->
      out_payload_byte == 8'd0 && !out_chunk_last)
    else $error("non-payload result carries payload bits");

  // After end of body, an error or truncation the decoder stays silent.
  a_terminal_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_kind != 2'(hcbd_pkg::KIND_DATA) |=> !out_valid)
    else $error("result item after end of body or error");

  // The input side is free right after reset.
  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_kind         (out_kind),
  .out_payload_byte (out_payload_byte),
  .out_chunk_last   (out_chunk_last)
);
